>>> rtl/core/keypad_code_lock_unit_defines.svh
// ----------------------------------------------------------------------------
// keypad_code_lock_unit_defines
// Assertion macros shared by the keypad code lock RTL.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_UNIT_DEFINES_SVH
`define KEYPAD_CODE_LOCK_UNIT_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define KCL_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Types and constants of the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // request types
  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_MOUSE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // virtual key codes with special handling
  localparam logic [7:0] KEY_NONE    = 8'd0;
  localparam logic [7:0] KEY_ENTER   = 8'd13;
  localparam logic [7:0] KEY_DIGIT_0 = 8'd48;
  localparam logic [7:0] KEY_DIGIT_9 = 8'd57;
  localparam logic [7:0] KEY_LWIN    = 8'd91;
  localparam logic [7:0] KEY_LSHIFT  = 8'd160;
  localparam logic [7:0] KEY_RSHIFT  = 8'd161;
  localparam logic [7:0] KEY_LCTRL   = 8'd162;
  localparam logic [7:0] KEY_RCTRL   = 8'd163;
  localparam logic [7:0] KEY_ALT     = 8'd164;
  localparam logic [7:0] KEY_RALT    = 8'd165;
  localparam logic [7:0] KEY_PLUS    = 8'd187;
  localparam logic [7:0] KEY_MINUS   = 8'd189;
  localparam logic [7:0] KEY_LBRACK  = 8'd219;
  localparam logic [7:0] KEY_RBRACK  = 8'd221;
  localparam logic [7:0] KEY_QUOTE   = 8'd222;

  // configuration register indexes
  localparam logic [2:0] CFG_MAIN_LO   = 3'd0;
  localparam logic [2:0] CFG_MAIN_HI   = 3'd1;
  localparam logic [2:0] CFG_MAIN_LEN  = 3'd2;
  localparam logic [2:0] CFG_SPARE_LO  = 3'd3;
  localparam logic [2:0] CFG_SPARE_HI  = 3'd4;
  localparam logic [2:0] CFG_SPARE_LEN = 3'd5;
  localparam logic [2:0] CFG_IDLE_LIM  = 3'd6;

  localparam logic [4:0] MAX_CODE_CHARS = 5'd16;

  // classified event passed from the front end to the back end
  typedef struct packed {
    logic [1:0] req_type;
    logic       is_enter;
    logic       ch_valid;   // key release that yields a character
    logic [7:0] ch;
  } kcl_evt_t;

endpackage

>>> rtl/core/kcl_queue.sv
// ----------------------------------------------------------------------------
// kcl_queue
// Two-entry queue of classified events between front and back end.
// ----------------------------------------------------------------------------
`include "keypad_code_lock_unit_defines.svh"

module kcl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kcl_pkg::kcl_evt_t push_data,
  output logic              full,
  input  logic              pop,
  output kcl_pkg::kcl_evt_t pop_data,
  output logic              empty
);
  import kcl_pkg::*;

  kcl_evt_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `KCL_ASSERT_NOW(a_q_no_underflow, !(pop && empty), "queue popped while empty")
  `KCL_ASSERT_NOW(a_q_count_bound, count_r != 2'd3, "queue count beyond depth")

endmodule

>>> rtl/core/kcl_front.sv
// ----------------------------------------------------------------------------
// kcl_front
// Accepts events, tracks both shift keys and maps key codes to characters.
// ----------------------------------------------------------------------------
module kcl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_key_code,
  input  logic              in_key_down,
  input  logic              q_full,
  output logic              q_push,
  output kcl_pkg::kcl_evt_t q_data
);
  import kcl_pkg::*;

  logic lshift_r, lshift_nxt;
  logic rshift_r, rshift_nxt;
  logic is_key;
  logic [8:0] key_ch;

  // bit 8 set: key gives no character
  function automatic logic [8:0] key_char(input logic [7:0] k, input logic shifted);
    logic [8:0] r;
    r = {1'b0, k};
    if (k inside {KEY_NONE, KEY_LWIN, KEY_LSHIFT, KEY_RSHIFT, KEY_LCTRL, KEY_RCTRL,
                  KEY_RALT}) begin
      r = {1'b1, k};
    end
    if (shifted) begin
      if (k inside {[KEY_DIGIT_0:KEY_DIGIT_9]}) begin
        case (k[3:0])
          4'd0:    r = {1'b0, 8'h29};  // )
          4'd1:    r = {1'b0, 8'h21};  // !
          4'd2:    r = {1'b0, 8'h40};  // @
          4'd3:    r = {1'b0, 8'h23};  // #
          4'd4:    r = {1'b0, 8'h24};  // $
          4'd5:    r = {1'b0, 8'h25};  // %
          4'd6:    r = {1'b0, 8'h5E};  // ^
          4'd7:    r = {1'b0, 8'h26};  // &
          4'd8:    r = {1'b0, 8'h2A};  // *
          default: r = {1'b0, 8'h28};  // (
        endcase
      end else if (k == KEY_MINUS) begin
        r = {1'b0, 8'h5F};
      end else if (k == KEY_PLUS) begin
        r = {1'b0, 8'h2B};
      end else if (k == KEY_LBRACK) begin
        r = {1'b0, 8'h7B};
      end else if (k == KEY_RBRACK) begin
        r = {1'b0, 8'h7D};
      end else if (k == KEY_QUOTE) begin
        r = {1'b0, 8'h22};
      end
    end else begin
      if (k == KEY_LBRACK) begin
        r = {1'b0, 8'h5B};
      end else if (k == KEY_RBRACK) begin
        r = {1'b0, 8'h5D};
      end else if (k == KEY_QUOTE) begin
        r = {1'b0, 8'h27};
      end
    end
    return r;
  endfunction

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_key   = (in_req_type == REQ_KEY);
  // shift keys themselves give no character, so the held state before them is fine
  assign key_ch   = key_char(in_key_code, lshift_r | rshift_r);

  always_comb begin
    q_data.req_type = in_req_type;
    q_data.is_enter = is_key && (in_key_code == KEY_ENTER);
    q_data.ch_valid = is_key && (in_key_code != KEY_ALT) && !in_key_down && !key_ch[8];
    q_data.ch       = key_ch[7:0];
  end

  always_comb begin
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    if (q_push && is_key) begin
      if (in_key_code == KEY_LSHIFT) begin
        lshift_nxt = in_key_down;
      end
      if (in_key_code == KEY_RSHIFT) begin
        rshift_nxt = in_key_down;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
    end else begin
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
    end
  end

endmodule

>>> rtl/core/kcl_back.sv
// ----------------------------------------------------------------------------
// kcl_back
// Code matching, idle timer, lock state, configuration and result register.
// ----------------------------------------------------------------------------
`include "keypad_code_lock_unit_defines.svh"

module kcl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  kcl_pkg::kcl_evt_t q_data,
  output logic              q_pop,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_swallow,
  output logic              out_lock_state
);
  import kcl_pkg::*;

  logic [127:0] main_chars_r, spare_chars_r;
  logic [4:0]   main_len_r, spare_len_r;
  logic [31:0]  idle_limit_r;

  logic         locked_r, locked_nxt;
  logic [4:0]   main_prog_r, main_prog_nxt;
  logic [4:0]   spare_prog_r, spare_prog_nxt;
  logic [31:0]  idle_r, idle_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_swallow_r, out_swallow_nxt;
  logic         out_lock_r, out_lock_nxt;

  logic [4:0]   main_len_eff, spare_len_eff;
  logic [31:0]  idle_inc;
  logic         locked_chk;
  logic         code_done;
  logic         unlock_now;
  logic [4:0]   main_adv, spare_adv;

  function automatic logic [4:0] eff_len(input logic [4:0] len);
    logic [4:0] r;
    r = len;
    if (len == 5'd0) begin
      r = 5'd1;
    end else if (len > MAX_CODE_CHARS) begin
      r = MAX_CODE_CHARS;
    end
    return r;
  endfunction

  // a progress at or beyond the length wraps before the compare
  function automatic logic [4:0] advance(input logic [4:0] prog, input logic [4:0] len,
                                         input logic [127:0] chars, input logic [7:0] ch);
    logic [3:0] pos;
    pos = (prog >= len) ? 4'd0 : prog[3:0];
    return (chars[{pos, 3'b000} +: 8] == ch) ? ({1'b0, pos} + 5'd1) : 5'd0;
  endfunction

  assign q_pop          = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_swallow    = out_swallow_r;
  assign out_lock_state = out_lock_r;

  assign main_len_eff  = eff_len(main_len_r);
  assign spare_len_eff = eff_len(spare_len_r);
  assign idle_inc      = ((q_data.req_type == REQ_TICK) && (idle_r != 32'hFFFF_FFFF)) ?
                         idle_r + 32'd1 : idle_r;
  assign locked_chk    = locked_r || (idle_inc > idle_limit_r);
  assign code_done     = (main_prog_r >= main_len_eff) || (spare_prog_r >= spare_len_eff);
  assign unlock_now    = q_data.is_enter && code_done;
  assign main_adv      = advance(main_prog_r, main_len_eff, main_chars_r, q_data.ch);
  assign spare_adv     = advance(spare_prog_r, spare_len_eff, spare_chars_r, q_data.ch);

  always_comb begin
    locked_nxt      = locked_r;
    main_prog_nxt   = main_prog_r;
    spare_prog_nxt  = spare_prog_r;
    idle_nxt        = idle_r;
    out_valid_nxt   = out_valid_r;
    out_swallow_nxt = out_swallow_r;
    out_lock_nxt    = out_lock_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      case (q_data.req_type)
        REQ_KEY: begin
          idle_nxt = 32'd0;
          if (unlock_now) begin
            locked_nxt      = 1'b0;
            main_prog_nxt   = 5'd0;
            spare_prog_nxt  = 5'd0;
            out_swallow_nxt = 1'b1;
            out_lock_nxt    = 1'b0;
          end else begin
            locked_nxt = locked_chk;
            if (q_data.ch_valid) begin
              main_prog_nxt  = main_adv;
              spare_prog_nxt = spare_adv;
            end
            out_swallow_nxt = locked_chk;
            out_lock_nxt    = locked_chk;
          end
        end
        REQ_MOUSE: begin
          idle_nxt        = 32'd0;
          locked_nxt      = locked_chk;
          out_swallow_nxt = locked_chk;
          out_lock_nxt    = locked_chk;
        end
        REQ_TICK: begin
          idle_nxt        = idle_inc;
          locked_nxt      = locked_chk;
          out_swallow_nxt = 1'b0;
          out_lock_nxt    = locked_chk;
        end
        default: begin
          // unused request type: state untouched
          out_swallow_nxt = 1'b0;
          out_lock_nxt    = locked_r;
        end
      endcase
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r     <= 1'b1;
      main_prog_r  <= 5'd0;
      spare_prog_r <= 5'd0;
      idle_r       <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      locked_r     <= locked_nxt;
      main_prog_r  <= main_prog_nxt;
      spare_prog_r <= spare_prog_nxt;
      idle_r       <= idle_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_swallow_r <= out_swallow_nxt;
    out_lock_r    <= out_lock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_chars_r  <= '0;
      spare_chars_r <= '0;
      main_len_r    <= 5'd1;
      spare_len_r   <= 5'd1;
      idle_limit_r  <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAIN_LO:   main_chars_r[63:0]    <= cfg_data;
        CFG_MAIN_HI:   main_chars_r[127:64]  <= cfg_data;
        CFG_MAIN_LEN:  main_len_r            <= cfg_data[4:0];
        CFG_SPARE_LO:  spare_chars_r[63:0]   <= cfg_data;
        CFG_SPARE_HI:  spare_chars_r[127:64] <= cfg_data;
        CFG_SPARE_LEN: spare_len_r           <= cfg_data[4:0];
        CFG_IDLE_LIM:  idle_limit_r          <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  `KCL_ASSERT_NEXT(a_unlock_clears, q_pop && (q_data.req_type == REQ_KEY) && unlock_now, !locked_r && (main_prog_r == 5'd0) && (spare_prog_r == 5'd0), "unlock did not clear state")
  `KCL_ASSERT_NOW(a_prog_bound, (main_prog_r <= MAX_CODE_CHARS) && (spare_prog_r <= MAX_CODE_CHARS), "code progress beyond maximum length")

endmodule

>>> rtl/core/keypad_code_lock_unit.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_unit
// Keypad combination lock: key, mouse and tick events in, swallow/lock out.
// ----------------------------------------------------------------------------
// One event is accepted every clock cycle while the queue is not full. The
// front end registers the shift keys and maps the key code to a character in
// the accepting cycle; the event then sits in a two-entry queue, and the back
// end updates code progress, idle count and lock state for it and loads the
// result register, from which the result is offered. The rate is set by the
// back end's state update: each event's progress and lock state feed the next.
// Configuration writes are always ready and take effect on the following
// cycle; write them only while no event is in flight.
// ----------------------------------------------------------------------------
module keypad_code_lock_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_key_code,
  input  logic        in_key_down,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_swallow,
  output logic        out_lock_state,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import kcl_pkg::*;

  kcl_evt_t push_data, pop_data;
  logic     q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  kcl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_key_code (in_key_code),
    .in_key_down (in_key_down),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  kcl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  kcl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_swallow    (out_swallow),
    .out_lock_state (out_lock_state)
  );

endmodule

>>> dv/keypad_code_lock_unit_tb.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_unit_tb
// Self-checking bench for the keypad code lock. A lock tracker class mirrors
// the shift, code-progress, idle and lock behaviour for every accepted event
// and checks each result transfer in order. Directed events come first, then
// phases of random codes, entry attempts, ticks and noise under random
// sender gaps and receiver stalls, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module keypad_code_lock_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam logic [1:0] REQ_SPARE_CODE = 2'd3;  // unused request type
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASE_ITEMS  = 90;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {ENTRY_CLEAN, ENTRY_WRONG, ENTRY_SHORT} entry_mode_t;

  typedef struct packed {
    logic swallow;
    logic lock_state;
  } lock_verdict_t;

  typedef struct {
    logic [7:0] key;
    bit         shifted;
  } stroke_t;

  // ---------------------------------------------------------------------------
  // lock tracker: own copy of registers and state, queue of due verdicts
  // ---------------------------------------------------------------------------
  class lock_tracker;
    logic [127:0] main_code, spare_code;
    logic [4:0]   main_len_reg, spare_len_reg;
    logic [31:0]  idle_limit;
    bit           locked, lshift, rshift;
    logic [4:0]   main_prog, spare_prog;
    logic [31:0]  idle_ticks;
    lock_verdict_t verdicts_due [$];
    int unsigned  failures;

    function new();
      main_code = '0; spare_code = '0;
      main_len_reg = 5'd1; spare_len_reg = 5'd1;
      idle_limit = '0;
      locked = 1'b1; lshift = 1'b0; rshift = 1'b0;
      main_prog = '0; spare_prog = '0;
      idle_ticks = '0;
      failures = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [63:0] data);
      case (idx)
        CFG_MAIN_LO:   main_code[63:0]    = data;
        CFG_MAIN_HI:   main_code[127:64]  = data;
        CFG_MAIN_LEN:  main_len_reg       = data[4:0];
        CFG_SPARE_LO:  spare_code[63:0]   = data;
        CFG_SPARE_HI:  spare_code[127:64] = data;
        CFG_SPARE_LEN: spare_len_reg      = data[4:0];
        CFG_IDLE_LIM:  idle_limit         = data[31:0];
        default: ;
      endcase
    endfunction

    function logic [4:0] clamp_len(input logic [4:0] len);
      if (len == 5'd0) return 5'd1;
      if (len > MAX_CODE_CHARS) return MAX_CODE_CHARS;
      return len;
    endfunction

    // returns 1 when the key yields a character
    function bit map_key(input logic [7:0] k, input bit shifted, output logic [7:0] ch);
      localparam logic [79:0] SHIFTED_DIGITS = ")!@#$%^&*(";
      ch = k;
      if (shifted) begin
        if (k >= KEY_DIGIT_0 && k <= KEY_DIGIT_9) begin
          ch = SHIFTED_DIGITS[8 * (9 - int'(k - KEY_DIGIT_0)) +: 8];
          return 1'b1;
        end
        case (k)
          KEY_MINUS:  begin ch = "_";  return 1'b1; end
          KEY_PLUS:   begin ch = "+";  return 1'b1; end
          KEY_LBRACK: begin ch = "{";  return 1'b1; end
          KEY_RBRACK: begin ch = "}";  return 1'b1; end
          KEY_QUOTE:  begin ch = "\""; return 1'b1; end
          default: ;
        endcase
      end else begin
        case (k)
          KEY_LBRACK: begin ch = "[";  return 1'b1; end
          KEY_RBRACK: begin ch = "]";  return 1'b1; end
          KEY_QUOTE:  begin ch = "'";  return 1'b1; end
          default: ;
        endcase
      end
      case (k)
        KEY_NONE, KEY_LSHIFT, KEY_RSHIFT, KEY_LCTRL, KEY_RCTRL, KEY_LWIN, KEY_RALT:
          return 1'b0;
        default: return 1'b1;
      endcase
    endfunction

    // full match (or stale progress past the length) wraps to zero first
    function logic [4:0] advance(input logic [4:0] prog, input logic [4:0] len,
                                 input logic [127:0] code, input logic [7:0] ch);
      logic [3:0] pos;
      pos = (prog >= len) ? 4'd0 : prog[3:0];
      return (code[pos * 8 +: 8] == ch) ? {1'b0, pos} + 5'd1 : 5'd0;
    endfunction

    function void note_event(input logic [1:0] t, input logic [7:0] k, input logic d);
      lock_verdict_t v;
      logic [4:0]    ml, sl;
      logic [7:0]    ch;
      ml = clamp_len(main_len_reg);
      sl = clamp_len(spare_len_reg);
      v.swallow = 1'b0;
      if (t == REQ_SPARE_CODE) begin
        v.lock_state = locked;
        verdicts_due.push_back(v);
        return;
      end
      if (t == REQ_TICK && idle_ticks != '1) idle_ticks++;
      if (idle_ticks > idle_limit) locked = 1'b1;
      if (t == REQ_MOUSE) begin
        idle_ticks = '0;
        v.swallow = locked;
      end else if (t == REQ_KEY) begin
        idle_ticks = '0;
        if (k == KEY_ALT) begin
          v.swallow = locked;
        end else begin
          if (k == KEY_LSHIFT) lshift = d;
          if (k == KEY_RSHIFT) rshift = d;
          if (k == KEY_ENTER && (main_prog >= ml || spare_prog >= sl)) begin
            locked = 1'b0;
            main_prog = '0;
            spare_prog = '0;
            v.swallow = 1'b1;
          end else begin
            if (!d && map_key(k, lshift | rshift, ch)) begin
              main_prog  = advance(main_prog, ml, main_code, ch);
              spare_prog = advance(spare_prog, sl, spare_code, ch);
            end
            v.swallow = locked;
          end
        end
      end
      v.lock_state = locked;
      verdicts_due.push_back(v);
    endfunction

    function void check_verdict(input logic sw, input logic ls);
      lock_verdict_t want;
      if (verdicts_due.size() == 0) begin
        failures++;
        $error("result transfer with nothing due: swallow %0d lock_state %0d", sw, ls);
        return;
      end
      want = verdicts_due.pop_front();
      if (sw !== want.swallow) begin
        failures++;
        $error("swallow mismatch: expected %0d, actual %0d", want.swallow, sw);
      end
      if (ls !== want.lock_state) begin
        failures++;
        $error("lock_state mismatch: expected %0d, actual %0d", want.lock_state, ls);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and signals
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [7:0]  in_key_code;
  logic        in_key_down;
  logic        out_valid;
  logic        out_stall;
  logic        out_swallow;
  logic        out_lock_state;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  keypad_code_lock_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_key_code    (in_key_code),
    .in_key_down    (in_key_down),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_swallow    (out_swallow),
    .out_lock_state (out_lock_state),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  lock_tracker book = new();

  stroke_t code_keys [2][16];
  int      code_len  [2];
  int      burst_left = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  int      sent = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic offer(input logic [1:0] t, input logic [7:0] k, input logic d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= t;
    in_key_code <= k;
    in_key_down <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_event(t, k, d);
    sent++;
  endtask

  // leaves cfg_valid high so back-to-back writes need one assignment per step
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, data);
  endtask

  task automatic set_codes(input logic [63:0] mlo, input logic [63:0] mhi,
                           input logic [4:0] mlen, input logic [63:0] slo,
                           input logic [63:0] shi, input logic [4:0] slen,
                           input logic [31:0] limit);
    cfg_write(CFG_MAIN_LO, mlo);
    cfg_write(CFG_MAIN_HI, mhi);
    cfg_write(CFG_MAIN_LEN, 64'(mlen));
    cfg_write(CFG_SPARE_LO, slo);
    cfg_write(CFG_SPARE_HI, shi);
    cfg_write(CFG_SPARE_LEN, 64'(slen));
    cfg_write(CFG_IDLE_LIM, 64'(limit));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return $urandom_range(1, 4);
    if (r < 16) return $urandom_range(5, 15);
    return 16;
  endfunction

  // a key stroke yielding a character that the match logic sees
  function automatic void pick_stroke(output stroke_t st, output logic [7:0] ch);
    do begin
      st.key     = 8'($urandom_range(1, 255));
      st.shifted = 1'($urandom_range(0, 1));
    end while (!book.map_key(st.key, st.shifted, ch) || st.key == KEY_ALT ||
               st.key == KEY_ENTER);
  endfunction

  task automatic setup_phase();
    logic [127:0] chars [2];
    logic [4:0]   len_reg [2];
    logic [31:0]  limit;
    logic [7:0]   ch;
    int           fill;
    for (int c = 0; c < 2; c++) begin
      fill = $urandom_range(0, 3);
      chars[c] = (fill == 0) ? '0 : (fill == 1) ? '1 :
                 {$urandom, $urandom, $urandom, $urandom};
      code_len[c] = pick_len();
      for (int i = 0; i < code_len[c]; i++) begin
        pick_stroke(code_keys[c][i], ch);
        chars[c][i * 8 +: 8] = ch;
      end
      len_reg[c] = 5'(code_len[c]);
      if (code_len[c] == 1 && $urandom_range(0, 1)) len_reg[c] = 5'd0;
      if (code_len[c] == 16 && $urandom_range(0, 1)) len_reg[c] = 5'($urandom_range(17, 31));
    end
    case ($urandom_range(0, 4))
      0:       limit = '0;
      1:       limit = '1;
      2:       limit = $urandom;
      default: limit = $urandom_range(1, 12);
    endcase
    set_codes(chars[0][63:0], chars[0][127:64], len_reg[0],
              chars[1][63:0], chars[1][127:64], len_reg[1], limit);
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic type_code(input int which, input entry_mode_t mode);
    stroke_t    st;
    logic [7:0] sk;
    int         cut, bad;
    offer(REQ_KEY, KEY_LSHIFT, 1'b0);
    offer(REQ_KEY, KEY_RSHIFT, 1'b0);
    cut = (mode == ENTRY_SHORT) ? $urandom_range(0, code_len[which] - 1) : code_len[which];
    bad = (mode == ENTRY_WRONG) ? $urandom_range(0, code_len[which] - 1) : -1;
    for (int i = 0; i < cut; i++) begin
      st = code_keys[which][i];
      if (i == bad) st.key = 8'($urandom_range(0, 255));
      sk = $urandom_range(0, 1) ? KEY_RSHIFT : KEY_LSHIFT;
      if (st.shifted) offer(REQ_KEY, sk, 1'b1);
      if ($urandom_range(0, 1)) offer(REQ_KEY, st.key, 1'b1);
      offer(REQ_KEY, st.key, 1'b0);
      if (st.shifted) offer(REQ_KEY, sk, 1'b0);
      if ($urandom_range(0, 7) == 0) offer(REQ_MOUSE, 8'($urandom), 1'($urandom));
    end
    offer(REQ_KEY, KEY_ENTER, 1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern in modes, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int mode_left;
    int stall_pct;
    mode_left = 0;
    stall_pct = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_verdict(out_swallow, out_lock_state);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int start, phase_start, pick, ticks;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_KEY;
    in_key_code <= KEY_NONE;
    in_key_down <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_MAIN_LO;
    cfg_data    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // main code "AB", spare code "!{", no idle relock
    set_codes(64'h4241, '0, 5'd2, 64'h7B21, '0, 5'd2, '1);
    offer(REQ_TICK, KEY_NONE, 1'b0);
    offer(REQ_MOUSE, 8'hFF, 1'b1);
    offer(REQ_SPARE_CODE, 8'hAA, 1'b1);
    offer(REQ_KEY, KEY_NONE, 1'b0);
    offer(REQ_KEY, KEY_ALT, 1'b1);
    offer(REQ_KEY, "A", 1'b0);
    offer(REQ_KEY, "B", 1'b1);
    offer(REQ_KEY, "B", 1'b0);
    offer(REQ_KEY, KEY_ENTER, 1'b1);          // main complete: unlock
    offer(REQ_MOUSE, KEY_NONE, 1'b0);
    offer(REQ_KEY, KEY_LSHIFT, 1'b1);
    offer(REQ_KEY, KEY_DIGIT_0 + 8'd1, 1'b0);  // '!'
    offer(REQ_KEY, KEY_RSHIFT, 1'b1);
    offer(REQ_KEY, KEY_LSHIFT, 1'b0);          // still shifted by the right key
    offer(REQ_KEY, KEY_LBRACK, 1'b0);          // '{'
    offer(REQ_KEY, KEY_RSHIFT, 1'b0);
    offer(REQ_KEY, KEY_LBRACK, 1'b0);          // '[' after full spare match
    offer(REQ_KEY, 8'hFF, 1'b1);
    offer(REQ_KEY, 8'hFF, 1'b0);
    settle();

    // zero length acts as one, oversize as sixteen; idle limit zero relocks on a tick
    set_codes(64'h41, '1, 5'd0, 64'h7B21, '0, 5'd31, '0);
    offer(REQ_TICK, KEY_NONE, 1'b1);
    offer(REQ_KEY, "A", 1'b0);
    offer(REQ_KEY, KEY_ENTER, 1'b0);
    settle();

    // progress left past a shortened length counts as a full match
    set_codes("HGFEDCBA", '1, 5'd16, '1, '1, 5'd16, '1);
    offer(REQ_KEY, "A", 1'b0);
    offer(REQ_KEY, "B", 1'b0);
    offer(REQ_KEY, "C", 1'b0);
    settle();
    set_codes("HGFEDCBA", '1, 5'd2, '1, '1, 5'd16, '1);
    offer(REQ_KEY, KEY_ENTER, 1'b1);
    settle();

    start = sent;
    hold_req = 1'b1;
    while (sent - start < RANDOM_ITEMS) begin
      setup_phase();
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS && sent - start < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          case ($urandom_range(0, 9))
            0, 1:    type_code($urandom_range(0, 1), ENTRY_WRONG);
            2:       type_code($urandom_range(0, 1), ENTRY_SHORT);
            default: type_code($urandom_range(0, 1), ENTRY_CLEAN);
          endcase
        end else if (pick < 65) begin
          ticks = (book.idle_limit <= 12) ? $urandom_range(0, int'(book.idle_limit) + 2)
                                          : $urandom_range(0, 4);
          repeat (ticks) offer(REQ_TICK, 8'($urandom), 1'($urandom));
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 4))
            offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'($urandom));
        end else begin
          if ($urandom_range(0, 1)) offer(REQ_MOUSE, 8'($urandom), 1'($urandom));
          else offer(REQ_KEY, KEY_ALT, 1'($urandom));
        end
      end
      settle();
    end

    if (book.failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
